@@ sv/lotp_pkg.sv @@
package lotp_pkg;

    localparam int VALUE_W = 16;
    localparam int DATA_W  = 21;
    localparam int COUNT_W = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DESCEND,
        ST_FETCH,
        ST_EMIT,
        ST_SUM
    } lotp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // store the accepted value, add it to the sum if odd; flag overflow if full
        logic idx_clear;    // start the walk at the root
        logic idx_left;     // move to the left child
        logic idx_sibling;  // move from a left child to its right sibling
        logic idx_parent;   // move up to the parent
        logic run_clear;    // end of run: clear count, sum and overflow flag
        logic sel_sum;      // result payload is the sum result
    } lotp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_left;     // current node has a left child
        logic has_sibling;  // current node is a left child with a right sibling
        logic at_root;      // current node is the root
    } lotp_status_t;

endpackage

@@ sv/level_order_tree_postorder_odd_sum.sv @@
// Collects signed 16-bit node values in level order into a complete binary tree
// held in heap layout (node i has children 2i+1 and 2i+2), adding every odd value
// to a 21-bit running sum. Loading takes one value per cycle. When the transfer
// marked by s_axis_tlast arrives, the input stalls and the block emits every
// stored value in post order on m_axis with tuser low, then one sum result with
// tuser high, tlast high and the truncation flag set if values beyond MAX_NODES
// were dropped; after that transfer a new run starts empty. The walk is done by a
// controller stepping a single index over a node memory with a registered read
// port: each emitted node is read from the memory in a descend or fetch state and
// then presented in the emit state, and every step down into a left child (one per
// odd index) adds one more pass through the descend state.
module level_order_tree_postorder_odd_sum #(
    parameter int MAX_NODES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    input  logic        s_axis_tlast,   // last_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] data_out, [21] truncated, [23:22] zero
    output logic        m_axis_tuser,   // [0] kind: 0 node value, 1 odd sum
    output logic        m_axis_tlast    // last_result
);
    import lotp_pkg::*;

    lotp_cmd_t          cmd;
    lotp_status_t       status;
    logic [DATA_W-1:0]  data_out;
    logic               truncated;

    // Sequencer: load, descend, fetch, emit and sum phases.
    lotp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // Node memory, count, odd sum, overflow flag and the walk index.
    lotp_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_value      (s_axis_tdata),
        .out_data      (data_out),
        .out_truncated (truncated)
    );

    // The sum result is both the kind-1 item and the end of the run.
    assign m_axis_tdata = {2'b00, truncated, data_out};
    assign m_axis_tuser = cmd.sel_sum;
    assign m_axis_tlast = cmd.sel_sum;

endmodule

@@ sv/lotp_datapath.sv @@
module lotp_datapath #(
    parameter int MAX_NODES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lotp_pkg::lotp_cmd_t               cmd,
    output lotp_pkg::lotp_status_t            status,
    input  logic [lotp_pkg::VALUE_W-1:0]      in_value,
    output logic [lotp_pkg::DATA_W-1:0]       out_data,
    output logic                              out_truncated
);
    import lotp_pkg::*;

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_NODES);

    logic [VALUE_W-1:0] node_mem [MAX_NODES];
    logic [VALUE_W-1:0] rd_data_reg;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic               ovf_reg, ovf_next;

    logic               has_room;
    logic [COUNT_W:0]   left_idx;
    logic [COUNT_W:0]   sib_idx;
    logic [DATA_W-1:0]  value_ext;
    logic [DATA_W-1:0]  node_ext;

    assign has_room  = count_reg < MAX_COUNT;
    assign left_idx  = {idx_reg, 1'b1};
    assign sib_idx   = {1'b0, idx_reg} + (COUNT_W+1)'(1);
    assign value_ext = {{(DATA_W-VALUE_W){in_value[VALUE_W-1]}}, in_value};
    assign node_ext  = {{(DATA_W-VALUE_W){rd_data_reg[VALUE_W-1]}}, rd_data_reg};

    assign status.has_left    = left_idx < {1'b0, count_reg};
    assign status.has_sibling = idx_reg[0] && (sib_idx < {1'b0, count_reg});
    assign status.at_root     = idx_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            if (has_room)
            begin
                count_next = count_reg + COUNT_W'(1);
                if (in_value[0])
                begin
                    acc_next = acc_reg + value_ext;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.run_clear)
        begin
            count_next = '0;
            acc_next   = '0;
            ovf_next   = 1'b0;
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_left)
        begin
            idx_next = left_idx[COUNT_W-1:0];
        end
        else if (cmd.idx_sibling)
        begin
            idx_next = sib_idx[COUNT_W-1:0];
        end
        else if (cmd.idx_parent)
        begin
            idx_next = (idx_reg - COUNT_W'(1)) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            node_mem[count_reg[ADDR_W-1:0]] <= in_value;
        end
        rd_data_reg <= node_mem[idx_reg[ADDR_W-1:0]];
    end

    assign out_data      = cmd.sel_sum ? acc_reg : node_ext;
    assign out_truncated = cmd.sel_sum & ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("node count beyond store capacity");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_clear |=> (count_reg == '0) && (acc_reg == '0) && !ovf_reg)
        else $error("run state not cleared after sum result");

    a_left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.idx_left |=> idx_reg < count_reg)
        else $error("walk moved to a node that is not stored");

endmodule

@@ sv/lotp_ctrl.sv @@
module lotp_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_last,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output lotp_pkg::lotp_cmd_t       cmd,
    input  lotp_pkg::lotp_status_t    status
);
    import lotp_pkg::*;

    lotp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_DESCEND;
                    end
                end
            end
            ST_DESCEND:
            begin
                // Walk down the left spine; the node read this cycle is ready in EMIT.
                if (status.has_left)
                begin
                    cmd.idx_left = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.at_root)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (status.has_sibling)
                    begin
                        cmd.idx_sibling = 1'b1;
                        state_next      = ST_DESCEND;
                    end
                    else
                    begin
                        cmd.idx_parent = 1'b1;
                        state_next     = ST_FETCH;
                    end
                end
            end
            ST_SUM:
            begin
                out_valid   = 1'b1;
                cmd.sel_sum = 1'b1;
                if (out_ready)
                begin
                    cmd.run_clear = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    a_sides_apart: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input and output sides active together");

    a_fetch_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |=> (state_reg == ST_EMIT))
        else $error("parent fetch not followed by emit");

    a_leaf_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DESCEND) && !status.has_left |=> (state_reg == ST_EMIT))
        else $error("descent did not stop at a node without left child");

endmodule
